[rtl/fmr_pkg.sv]
// Package: widths and controller states for the fraction multiply and reduce block.
package fmr_pkg;
  localparam int OperandWidthDef = 16;
  localparam int ResultWidth     = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } fmr_state_t;
endpackage

[rtl/fmr_divider.sv]
// Bit-serial restoring divider on magnitudes, one quotient bit per cycle.
module fmr_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  // one shift-subtract step
  always_comb begin
    shifted  = {rem_r[W-1:0], q_r[W-1]};
    trial    = shifted - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign busy      = busy_r;
  assign quotient  = q_r;
  assign remainder = rem_r[W-1:0];
endmodule

[rtl/fraction_multiply_reduce.sv]
// Top level: multiplies two fractions and reduces the product by its gcd.
//
//  channel | direction | beat contents
//  in_     | slave     | tdata: a_num, a_den, b_num, b_den
//  out_    | master    | tdata: res_num, res_den; tuser: zero_fault
//
// One item at a time. Products are formed by a serial shift-add multiplier,
// one multiplier bit per cycle. Each Euclid step goes through launch, start,
// the divider's shift-subtract steps and an update of x and y; each final
// division goes through launch, start and the divider steps. Reset is
// synchronous, active low.
// A result waits in the output register while out_tready is low.
module fraction_multiply_reduce #(
  parameter int OPERAND_WIDTH = fmr_pkg::OperandWidthDef
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] in_tdata,   // a_num, a_den, b_num, b_den
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [2*fmr_pkg::ResultWidth-1:0]  out_tdata,  // res_num, res_den
  output logic                               out_tuser   // zero_fault
);
  import fmr_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;
  localparam int CW = $clog2(OW + 1);

  fmr_state_t state_r, state_nxt;

  logic [PW-1:0] mcand_n_r, mcand_d_r;
  logic [OW-1:0] mplr_n_r, mplr_d_r;
  logic [PW-1:0] acc_n_r, acc_d_r;
  logic [CW-1:0] mcnt_r;
  logic          neg_n_r, neg_d_r;
  logic [PW-1:0] pn_r, pd_r;          // signed products
  logic [PW-1:0] x_r, y_r;            // Euclid operands, signed
  logic          div_go_r, div_go_nxt;
  logic          div_pend_r;          // Euclid division launched, result not yet taken
  logic          div_idle;
  logic          out_valid_r;
  logic [2*ResultWidth-1:0] out_data_r;
  logic          out_fault_r;

  logic          div_start;
  logic [PW-1:0] div_a, div_b;
  logic          div_busy;
  logic [PW-1:0] div_q, div_rm;

  logic signed [OW-1:0] an, ad, bn, bd;
  assign an = in_tdata[OW-1:0];
  assign ad = in_tdata[2*OW-1:OW];
  assign bn = in_tdata[3*OW-1:2*OW];
  assign bd = in_tdata[4*OW-1:3*OW];

  function automatic logic [PW-1:0] mag(input logic [PW-1:0] v);
    mag = v[PW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [OW-1:0] mag_o(input logic [OW-1:0] v);
    mag_o = v[OW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [PW-1:0] sgn_rem;   // truncating remainder takes the dividend's sign
  logic [PW-1:0] sgn_quo;   // quotient negative when signs differ
  logic [PW-1:0] divd_src;
  assign divd_src = (state_r == ST_DIVD) ? pd_r : pn_r;
  assign sgn_rem  = x_r[PW-1] ? (~div_rm + 1'b1) : div_rm;
  assign sgn_quo  = (divd_src[PW-1] ^ x_r[PW-1]) ? (~div_q + 1'b1) : div_q;

  assign div_a = (state_r == ST_GCD) ? mag(x_r) : mag(divd_src);
  assign div_b = (state_r == ST_GCD) ? mag(y_r) : mag(x_r);
  assign div_start = div_go_r;
  // divider neither starting nor running: its result is settled
  assign div_idle  = !div_go_r && !div_busy;

  fmr_divider #(.W(PW)) u_div (
    .clk, .rst_n,
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rm)
  );

  assign in_tready = (state_r == ST_IDLE);

  // next state and divider launch
  always_comb begin
    state_nxt  = state_r;
    div_go_nxt = 1'b0;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:  if (mcnt_r == '0) state_nxt = ST_GCD;
      ST_GCD: begin
        if (div_idle && !div_pend_r) begin
          if (y_r == '0) begin
            if (x_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt  = ST_DIVN;
              div_go_nxt = 1'b1;
            end
          end else begin
            div_go_nxt = 1'b1;
          end
        end
      end
      ST_DIVN: begin
        if (div_idle) begin
          state_nxt  = ST_DIVD;
          div_go_nxt = 1'b1;
        end
      end
      ST_DIVD: if (div_idle) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_go_r    <= 1'b0;
      div_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= div_go_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            mcand_n_r <= PW'(mag_o(an));
            mplr_n_r  <= mag_o(bn);
            mcand_d_r <= PW'(mag_o(ad));
            mplr_d_r  <= mag_o(bd);
            neg_n_r   <= an[OW-1] ^ bn[OW-1];
            neg_d_r   <= ad[OW-1] ^ bd[OW-1];
            acc_n_r   <= '0;
            acc_d_r   <= '0;
            mcnt_r    <= CW'(OW);
          end
        end
        ST_MUL: begin
          if (mcnt_r != '0) begin
            if (mplr_n_r[0]) acc_n_r <= acc_n_r + mcand_n_r;
            if (mplr_d_r[0]) acc_d_r <= acc_d_r + mcand_d_r;
            mcand_n_r <= mcand_n_r << 1;
            mcand_d_r <= mcand_d_r << 1;
            mplr_n_r  <= mplr_n_r >> 1;
            mplr_d_r  <= mplr_d_r >> 1;
            mcnt_r    <= mcnt_r - 1'b1;
          end else begin
            pn_r <= neg_n_r ? (~acc_n_r + 1'b1) : acc_n_r;
            pd_r <= neg_d_r ? (~acc_d_r + 1'b1) : acc_d_r;
            x_r  <= neg_n_r ? (~acc_n_r + 1'b1) : acc_n_r;
            y_r  <= neg_d_r ? (~acc_d_r + 1'b1) : acc_d_r;
          end
        end
        ST_GCD: begin
          if (div_idle) begin
            if (div_pend_r) begin
              // one Euclid step: (x, y) becomes (y, x rem y)
              x_r        <= y_r;
              y_r        <= sgn_rem;
              div_pend_r <= 1'b0;
            end else if (y_r != '0) begin
              div_pend_r <= 1'b1;
            end else if (x_r == '0) begin
              out_data_r  <= '0;
              out_fault_r <= 1'b1;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_DIVN: begin
          if (div_idle) begin
            out_data_r[ResultWidth-1:0] <= ResultWidth'($signed(sgn_quo));
          end
        end
        ST_DIVD: begin
          if (div_idle) begin
            out_data_r[2*ResultWidth-1:ResultWidth] <= ResultWidth'($signed(sgn_quo));
            out_fault_r <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fault_r;
endmodule

[rtl/fmr_checker.sv]
// Port-level checker for the fraction multiply and reduce block, with its bind.
module fmr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tuser,
  input logic [63:0] out_tdata
);
  // one item at a time: no new beat taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  // a fault result carries 0/0
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0)) else $error("fault beat not zero");

  // a result never shows in the cycle after an input beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");
endmodule

bind fraction_multiply_reduce fmr_checker u_fmr_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tuser, .out_tdata
);
